// File: design/smcp_pkg.sv
// Package for the serial motor command parser.
// Holds the character codes, action codes and the command queue entry type.
// No dependencies; all design files but smcp_if use it by scoped names.
package smcp_pkg;

	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_T       = 8'h74;
	localparam logic [7:0] CH_P       = 8'h70;
	localparam logic [7:0] CH_A       = 8'h61;
	localparam logic [7:0] CH_L       = 8'h6C;
	localparam logic [7:0] CH_R       = 8'h72;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_MINUS   = 8'h2D;

	localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;
	localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		ACT_TOGGLE = 3'd0,
		ACT_PRINT  = 3'd1,
		ACT_MODE   = 3'd2,
		ACT_LEFT   = 3'd3,
		ACT_RIGHT  = 3'd4
	} smcp_action_t;

	typedef struct packed {
		smcp_action_t       action;
		logic signed [31:0] value;
	} smcp_exec_t;

	typedef struct packed {
		logic push;
	} smcp_wr_ctl_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} smcp_rd_ctl_t;

endpackage

// File: design/smcp_if.sv
// Channel interfaces of the serial motor command parser.
// Byte input, threshold write and result output, each with valid and ready.
// Depends on nothing.
interface smcp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface smcp_cfg_if;
	logic        valid;
	logic        ready;
	logic [30:0] toggle_threshold;
	modport source (output valid, output toggle_threshold, input ready);
	modport sink (input valid, input toggle_threshold, output ready);
endinterface

interface smcp_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic signed [31:0] value;
	logic               auto_on;
	logic               stop_motors;
	logic               led_on;
	modport source (output valid, output action, output value, output auto_on,
		output stop_motors, output led_on, input ready);
	modport sink (input valid, input action, input value, input auto_on,
		input stop_motors, input led_on, output ready);
endinterface

// File: design/smcp_front.sv
// Front end: takes received bytes, tracks the pending command and gathers the number.
// Pushes a decoded command into the queue when a terminating byte follows a known letter and number characters.
// Depends on smcp_pkg and smcp_rx_if.
module smcp_front #(
	parameter int MAX_CHARS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	smcp_rx_if.sink                  rx,
	input  logic                     q_full,
	output smcp_pkg::smcp_wr_ctl_t   q_wr,
	output smcp_pkg::smcp_exec_t     q_data
);

	localparam int CW = $clog2(MAX_CHARS + 1);

	logic                   armed_q;
	logic                   known_q;
	smcp_pkg::smcp_action_t cmd_q;
	logic [CW-1:0]          count_q;
	logic                   neg_q;
	logic                   done_q;
	logic [31:0]            mag_q;

	logic                   accept;
	logic                   is_letter;
	logic                   is_digit;
	logic                   is_minus;
	logic                   do_gather;
	logic                   do_exec;
	logic [35:0]            mag_next;
	logic                   letter_known;
	smcp_pkg::smcp_action_t letter_cmd;

	assign accept    = rx.valid && rx.ready;
	assign rx.ready  = !q_full;
	assign is_letter = (rx.rx_byte >= smcp_pkg::CH_LOWER_A) && (rx.rx_byte <= smcp_pkg::CH_LOWER_Z);
	assign is_digit  = (rx.rx_byte >= smcp_pkg::CH_ZERO) && (rx.rx_byte <= smcp_pkg::CH_NINE);
	assign is_minus  = (rx.rx_byte == smcp_pkg::CH_MINUS);
	assign do_gather = armed_q && (is_digit || is_minus) && (count_q < CW'(MAX_CHARS));
	assign do_exec   = !is_letter && !do_gather && armed_q && (count_q != '0);

	always_comb begin
		mag_next = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {32'b0, rx.rx_byte[3:0]};
		if (mag_next > smcp_pkg::MAG_LIMIT) begin
			mag_next = smcp_pkg::MAG_LIMIT;
		end
	end

	always_comb begin
		letter_known = 1'b1;
		letter_cmd   = smcp_pkg::ACT_PRINT;
		unique case (rx.rx_byte)
			smcp_pkg::CH_T: letter_cmd = smcp_pkg::ACT_TOGGLE;
			smcp_pkg::CH_P: letter_cmd = smcp_pkg::ACT_PRINT;
			smcp_pkg::CH_A: letter_cmd = smcp_pkg::ACT_MODE;
			smcp_pkg::CH_L: letter_cmd = smcp_pkg::ACT_LEFT;
			smcp_pkg::CH_R: letter_cmd = smcp_pkg::ACT_RIGHT;
			default: letter_known = 1'b0;
		endcase
	end

	always_comb begin
		q_data.action = cmd_q;
		if (neg_q) begin
			q_data.value = -$signed(mag_q);
		end else if (mag_q[31]) begin
			q_data.value = $signed(smcp_pkg::POS_MAX);
		end else begin
			q_data.value = $signed(mag_q);
		end
		q_wr.push = accept && do_exec && known_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			known_q <= 1'b0;
			cmd_q   <= smcp_pkg::ACT_TOGGLE;
			count_q <= '0;
			neg_q   <= 1'b0;
			done_q  <= 1'b0;
			mag_q   <= '0;
		end else if (accept) begin
			if (is_letter) begin
				armed_q <= 1'b1;
				known_q <= letter_known;
				cmd_q   <= letter_cmd;
				count_q <= '0;
				neg_q   <= 1'b0;
				done_q  <= 1'b0;
				mag_q   <= '0;
			end else if (do_gather) begin
				count_q <= count_q + CW'(1);
				if (!done_q) begin
					if (is_minus) begin
						if (count_q == '0) begin
							neg_q <= 1'b1;
						end else begin
							done_q <= 1'b1;
						end
					end else begin
						mag_q <= mag_next[31:0];
					end
				end
			end else begin
				armed_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/smcp_queue.sv
// Short command queue between the front end and the back end.
// Register storage with read and write pointers and a fill count.
// Depends on smcp_pkg.
module smcp_queue #(
	parameter int DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  smcp_pkg::smcp_wr_ctl_t wr,
	input  smcp_pkg::smcp_exec_t   wr_data,
	output logic                   full,
	input  logic                   pop,
	output smcp_pkg::smcp_rd_ctl_t rd,
	output smcp_pkg::smcp_exec_t   rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	smcp_pkg::smcp_exec_t mem_q [DEPTH];
	logic [AW-1:0]        wr_ptr_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [NW-1:0]        count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == NW'(DEPTH));
	assign rd.empty = (count_q == '0);
	assign rd.pop  = do_pop;
	assign do_push = wr.push && !full;
	assign do_pop  = pop && !rd.empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

// File: design/smcp_back.sv
// Back end: carries out queued commands against the LED and auto mode state.
// Holds the toggle threshold and the registered result request.
// Depends on smcp_pkg, smcp_cfg_if and smcp_res_if.
module smcp_back (
	input  logic                   clk,
	input  logic                   arst_n,
	smcp_cfg_if.sink               cfg,
	smcp_res_if.source             res,
	input  smcp_pkg::smcp_rd_ctl_t q_rd,
	input  smcp_pkg::smcp_exec_t   q_data,
	output logic                   q_pop
);

	logic [30:0]        thr_q;
	logic               auto_q;
	logic               led_q;
	logic               res_valid_q;
	logic [2:0]         res_action_q;
	logic signed [31:0] res_value_q;
	logic               res_auto_q;
	logic               res_stop_q;
	logic               res_led_q;

	logic               emit;
	logic               auto_next;
	logic               led_next;
	logic               stop;

	assign cfg.ready = 1'b1;
	assign q_pop     = !q_rd.empty && (!res_valid_q || res.ready);

	always_comb begin
		emit      = 1'b0;
		auto_next = auto_q;
		led_next  = led_q;
		stop      = 1'b0;
		unique case (q_data.action)
			smcp_pkg::ACT_TOGGLE: begin
				if (q_data.value > $signed({1'b0, thr_q})) begin
					emit     = 1'b1;
					led_next = !led_q;
				end
			end
			smcp_pkg::ACT_PRINT: emit = 1'b1;
			smcp_pkg::ACT_MODE: begin
				emit      = 1'b1;
				auto_next = !auto_q;
				stop      = auto_q;
			end
			smcp_pkg::ACT_LEFT, smcp_pkg::ACT_RIGHT: emit = !auto_q;
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= 31'd300;
			auto_q      <= 1'b0;
			led_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				thr_q <= cfg.toggle_threshold;
			end
			if (q_rd.pop) begin
				auto_q      <= auto_next;
				led_q       <= led_next;
				res_valid_q <= emit;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd.pop) begin
			res_action_q <= q_data.action;
			res_value_q  <= q_data.value;
			res_auto_q   <= auto_next;
			res_stop_q   <= stop;
			res_led_q    <= led_next;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.action      = res_action_q;
	assign res.value       = res_value_q;
	assign res.auto_on     = res_auto_q;
	assign res.stop_motors = res_stop_q;
	assign res.led_on      = res_led_q;

endmodule

// File: design/serial_motor_command_parser.sv
// Serial motor command parser, top level: front end, command queue and back end.
// Takes one byte per cycle while the queue has room; the front end never waits on a result.
// A terminating byte's command enters the queue on accept and the result register on pop.
// Sustained throughput is one byte per cycle while the queue has room.
// Reset clears the parser, the queue, the LED and auto mode, and sets the threshold to 300.
// Depends on smcp_pkg, smcp_if, smcp_front, smcp_queue and smcp_back.
module serial_motor_command_parser #(
	parameter int MAX_CHARS = 10
) (
	input logic        clk,
	input logic        arst_n,
	smcp_rx_if.sink    rx,
	smcp_cfg_if.sink   cfg,
	smcp_res_if.source res
);

	smcp_pkg::smcp_wr_ctl_t q_wr;
	smcp_pkg::smcp_rd_ctl_t q_rd;
	smcp_pkg::smcp_exec_t   q_in;
	smcp_pkg::smcp_exec_t   q_out;
	logic                   q_full;
	logic                   q_pop;

	smcp_front #(
		.MAX_CHARS(MAX_CHARS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_data (q_in)
	);

	smcp_queue #(
		.DEPTH(smcp_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_in),
		.full    (q_full),
		.pop     (q_pop),
		.rd      (q_rd),
		.rd_data (q_out)
	);

	smcp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.res    (res),
		.q_rd   (q_rd),
		.q_data (q_out),
		.q_pop  (q_pop)
	);

endmodule

// File: sim/tb_top.sv
// Testbench for serial_motor_command_parser: drives received bytes, threshold writes
// and result back-pressure, and checks each result against a cycle-free predictor.
// Depends on smcp_pkg, smcp_if and the design files.
`timescale 1ns / 100ps

module tb_top;
	import smcp_pkg::*;

	localparam int MAX_CHARS = 10;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_BYTES = 300;

	typedef struct {
		smcp_action_t       action;
		logic signed [31:0] value;
		logic               auto_on;
		logic               stop_motors;
		logic               led_on;
	} motor_action_t;

	class command_tracker;
		logic [30:0]   threshold;
		logic [7:0]    letter;
		logic          armed;
		logic [3:0]    count;
		logic          negative;
		logic          done;
		logic [31:0]   magnitude;
		logic          auto_mode;
		logic          led;
		motor_action_t pending[$];
		int            mismatch_count;

		function new();
			threshold = 31'd300;
			letter = '0;
			armed = 1'b0;
			count = '0;
			negative = 1'b0;
			done = 1'b0;
			magnitude = '0;
			auto_mode = 1'b0;
			led = 1'b0;
			mismatch_count = 0;
		endfunction

		function void queue_action(smcp_action_t act, longint v, logic stop);
			motor_action_t r;
			r.action = act;
			r.value = v[31:0];
			r.auto_on = auto_mode;
			r.stop_motors = stop;
			r.led_on = led;
			pending.push_back(r);
		endfunction

		function void take_byte(logic [7:0] ch);
			logic        is_num;
			logic [63:0] wide;
			longint      v;
			logic        leaving;
			is_num = (ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_MINUS;
			if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
				armed = 1'b1;
				letter = ch;
				count = '0;
				negative = 1'b0;
				done = 1'b0;
				magnitude = '0;
			end else if (armed && is_num && count < MAX_CHARS) begin
				if (!done) begin
					if (ch == CH_MINUS) begin
						if (count == 0)
							negative = 1'b1;
						else
							done = 1'b1;
					end else begin
						wide = {32'd0, magnitude} * 64'd10 + {56'd0, ch - CH_ZERO};
						if (wide > 64'h8000_0000)
							wide = 64'h8000_0000;
						magnitude = wide[31:0];
					end
				end
				count = count + 4'd1;
			end else if (armed && count != 0) begin
				armed = 1'b0;
				if (negative)
					v = -longint'(magnitude);
				else if (magnitude > POS_MAX)
					v = longint'(POS_MAX);
				else
					v = longint'(magnitude);
				case (letter)
					CH_T: begin
						if (v > longint'(threshold)) begin
							led = !led;
							queue_action(ACT_TOGGLE, v, 1'b0);
						end
					end
					CH_P: queue_action(ACT_PRINT, v, 1'b0);
					CH_A: begin
						leaving = auto_mode;
						auto_mode = !auto_mode;
						queue_action(ACT_MODE, v, leaving);
					end
					CH_L: begin
						if (!auto_mode)
							queue_action(ACT_LEFT, v, 1'b0);
					end
					CH_R: begin
						if (!auto_mode)
							queue_action(ACT_RIGHT, v, 1'b0);
					end
					default: ;
				endcase
			end else begin
				armed = 1'b0;
			end
		endfunction

		function void check_result(logic [2:0] act, logic signed [31:0] val, logic auto_on,
				logic stop, logic led_on);
			motor_action_t e;
			if (pending.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result: action %0d value %0d auto %b stop %b led %b",
						act, val, auto_on, stop, led_on);
				return;
			end
			e = pending.pop_front();
			if (act !== e.action || val !== e.value || auto_on !== e.auto_on ||
					stop !== e.stop_motors || led_on !== e.led_on) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Mismatch: expected action %0d value %0d auto %b stop %b led %b, %s",
						e.action, e.value, e.auto_on, e.stop_motors, e.led_on,
						$sformatf("got action %0d value %0d auto %b stop %b led %b",
						act, val, auto_on, stop, led_on));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	smcp_rx_if  rx_ch();
	smcp_cfg_if cfg_ch();
	smcp_res_if res_ch();

	serial_motor_command_parser #(
		.MAX_CHARS(MAX_CHARS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.cfg(cfg_ch),
		.res(res_ch)
	);

	command_tracker tracker;
	int             bytes_sent;
	int             rx_idle_pct;
	int             res_idle_pct;
	int             res_hold_cycles;

	localparam logic [7:0] DIRECTED [31] = '{
		CH_P, CH_MINUS, CH_MINUS, "5", 8'hFF,
		"x", "7", " ",
		"5",
		CH_T, "9", ",",
		CH_L, CH_MINUS, 8'h00,
		CH_A, "8", ".",
		CH_R, "3", "/",
		"q", " ",
		CH_T, "5", "0", "0", "#",
		CH_A, "1", ":"
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAIL serial_motor_command_parser");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				tracker.threshold = cfg_ch.toggle_threshold;
			if (rx_ch.valid && rx_ch.ready)
				tracker.take_byte(rx_ch.rx_byte);
			if (res_ch.valid && res_ch.ready)
				tracker.check_result(res_ch.action, res_ch.value, res_ch.auto_on,
					res_ch.stop_motors, res_ch.led_on);
		end
	end

	// The long hold is counted here so that the sender keeps offering bytes meanwhile.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (res_hold_cycles != 0) begin
				res_ch.ready <= 1'b0;
				repeat (res_hold_cycles - 1) @(negedge clk);
				res_hold_cycles = 0;
			end else if (res_idle_pct != 0 && $urandom_range(0, 99) < res_idle_pct) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 11)) @(negedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] random_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] random_num_char(int minus_pct);
		return ($urandom_range(0, 99) < minus_pct) ? CH_MINUS : random_digit();
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
			gap = $urandom_range(1, 12);
		@(negedge clk);
		if (gap != 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [30:0] thr);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.toggle_threshold <= thr;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_command();
		logic [7:0] seq[$];
		logic [7:0] letter;
		logic [7:0] b;
		int         pick;
		string      num;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
		end else begin
			pick = $urandom_range(0, 99);
			letter = pick < 22 ? CH_T : pick < 40 ? CH_P : pick < 60 ? CH_A :
				pick < 75 ? CH_L : pick < 90 ? CH_R : 8'(CH_LOWER_A + $urandom_range(0, 25));
			seq.push_back(letter);
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
			end else if (pick < 30 && letter == CH_T) begin
				num = $sformatf("%0d", longint'(tracker.threshold) +
					longint'($urandom_range(0, 2)) - 1);
				for (int i = 0; i < num.len(); i++)
					seq.push_back(num[i]);
			end else if (pick < 75) begin
				if ($urandom_range(0, 4) == 0)
					seq.push_back(CH_MINUS);
				repeat ($urandom_range(1, 4)) seq.push_back(random_digit());
			end else if (pick < 88) begin
				if ($urandom_range(0, 1) == 0)
					seq.push_back(CH_MINUS);
				seq.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
				repeat ($urandom_range(7, 9)) seq.push_back(random_digit());
			end else if (pick < 94) begin
				repeat (MAX_CHARS) seq.push_back(random_num_char(20));
				seq.push_back(random_digit());
			end else begin
				repeat ($urandom_range(1, MAX_CHARS)) seq.push_back(random_num_char(50));
			end
			if ($urandom_range(0, 19) != 0) begin
				do b = 8'($urandom_range(0, 255));
				while ((b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
					(b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS);
				seq.push_back(b);
			end
		end
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	initial begin
		int target;
		tracker = new();
		bytes_sent = 0;
		rx_idle_pct = 20;
		res_idle_pct = 15;
		res_hold_cycles = 0;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.toggle_threshold = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i]);

		for (int ph = 0; ph < 5; ph++) begin
			wait_all_results();
			case (ph)
				0: write_threshold(31'd0);
				1: write_threshold(31'h7FFF_FFFF);
				2: write_threshold(31'($urandom_range(0, 2000)));
				3: write_threshold(31'($urandom));
				default: write_threshold(31'd300);
			endcase
			if (ph == 4) begin
				rx_idle_pct = 0;
				res_idle_pct = 0;
			end
			if (ph == 2) begin
				rx_idle_pct = 0;
				res_hold_cycles = 400;
			end else if (ph == 3) begin
				rx_idle_pct = 20;
			end
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target)
				send_command();
		end

		wait_all_results();
		if (tracker.mismatch_count == 0 && tracker.pending.size() == 0)
			$display("PASS serial_motor_command_parser");
		else
			$display("FAIL serial_motor_command_parser");
		$finish;
	end

endmodule

// File: filelist.f
design/smcp_pkg.sv
design/smcp_if.sv
design/smcp_front.sv
design/smcp_queue.sv
design/smcp_back.sv
design/serial_motor_command_parser.sv
sim/tb_top.sv
